// File: rtl/oabf_pkg.sv
// Shared types and constants for the overlay alpha blend and fade block.
`default_nettype none
package oabf_pkg;

  localparam int SampleW = 8;
  localparam int RegW    = 11;
  localparam int FactorW = 9;

  localparam logic       REG_FADE_COUNT = 1'b0;
  localparam logic       REG_FADE_MAX   = 1'b1;

  localparam logic       REQ_IMAGE = 1'b0;
  localparam logic       REQ_BOX   = 1'b1;

  localparam logic [FactorW-1:0] FACTOR_NONE = 9'd255;
  localparam logic [FactorW-1:0] FACTOR_FULL = 9'd256;

  localparam logic [7:0]  BOX_ALPHA   = 8'd192;
  localparam logic [16:0] IMG_ROUND   = 17'h00080;
  localparam logic [16:0] BOX_ROUND   = 17'h00809;
  localparam logic signed [17:0] BLEND_ROUND = 18'sd128;

  typedef struct packed {
    logic               busy;
    logic [FactorW-1:0] factor;
  } fade_status_t;

endpackage
`default_nettype wire

// File: rtl/overlay_alpha_blend_fade.sv
// Each accepted request passes through the three-stage blend pipeline to the master side.
// Throughput: one request per cycle while neither m_tready nor the fade divider stalls it.
// A fade register write holds s_tready low while the
// sequential divider recomputes the fade factor, one quotient bit per cycle.
// Reset sets both fade registers to -1, the fade factor to 255, and empties
// the pipeline.
`default_nettype none
module overlay_alpha_blend_fade (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [oabf_pkg::RegW-1:0]   cfg_data,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [23:0]                 s_tdata,  // dest_sample, src_sample, src_alpha
  input  wire logic                        s_tuser,  // req_type
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [7:0]                       m_tdata,  // out_sample
  output logic                             m_tuser   // changed
);
  import oabf_pkg::*;

  fade_status_t status;

  oabf_fade u_fade (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status)
  );

  oabf_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .status      (status),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_type     (s_tuser),
    .in_dest     (s_tdata[7:0]),
    .in_src      (s_tdata[15:8]),
    .in_alpha    (s_tdata[23:16]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_sample  (m_tdata),
    .out_changed (m_tuser)
  );

endmodule
`default_nettype wire

// File: rtl/oabf_fade.sv
// Fade register file and the iterative divider that derives the fade factor.
`default_nettype none
module oabf_fade (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [oabf_pkg::RegW-1:0]  cfg_data,
  output oabf_pkg::fade_status_t          status
);
  import oabf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]               state;
  logic signed [RegW-1:0]   fade_count;
  logic signed [RegW-1:0]   fade_max;
  logic [FactorW-1:0]       factor;
  logic [18:0]              rem;
  logic [18:0]              dsh;
  logic [FactorW-1:0]       quo;
  logic [3:0]               step;

  logic                     ge;
  logic [FactorW-1:0]       quo_next;

  assign ge       = rem >= dsh;
  assign quo_next = {quo[FactorW-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fade_count <= '1;
      fade_max   <= '1;
      factor     <= FACTOR_NONE;
    end else if (cfg_we) begin
      if (cfg_index == REG_FADE_COUNT) begin
        fade_count <= cfg_data;
      end else begin
        fade_max <= cfg_data;
      end
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_LOAD: begin
          if (fade_max <= 0 || fade_count < 0) begin
            factor <= FACTOR_NONE;
            state  <= ST_IDLE;
          end else if (fade_count >= fade_max) begin
            factor <= FACTOR_FULL;
            state  <= ST_IDLE;
          end else begin
            rem   <= {fade_count[9:0], 9'd0} + {9'd0, fade_max[9:0]};
            dsh   <= {fade_max[9:0], 9'd0};
            quo   <= '0;
            step  <= 4'd8;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (ge) begin
            rem <= rem - dsh;
          end
          dsh  <= dsh >> 1;
          quo  <= quo_next;
          step <= step - 4'd1;
          if (step == 4'd0) begin
            factor <= quo_next;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign status.busy   = state != ST_IDLE;
  assign status.factor = factor;

endmodule
`default_nettype wire

// File: rtl/oabf_blend.sv
// Three-stage blend pipeline: alpha scaling, difference product, rounding.
`default_nettype none
module oabf_blend (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire oabf_pkg::fade_status_t       status,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_type,
  input  wire logic [oabf_pkg::SampleW-1:0] in_dest,
  input  wire logic [oabf_pkg::SampleW-1:0] in_src,
  input  wire logic [oabf_pkg::SampleW-1:0] in_alpha,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [oabf_pkg::SampleW-1:0]      out_sample,
  output logic                              out_changed
);
  import oabf_pkg::*;

  logic                      v1;
  logic                      v2;
  logic                      ready1;
  logic                      ready2;
  logic                      ready3;

  logic [SampleW-1:0]        a1;
  logic signed [SampleW:0]   diff1;
  logic [SampleW-1:0]        dest1;
  logic                      skip1;

  logic signed [17:0]        d2;
  logic [SampleW-1:0]        dest2;
  logic                      skip2;

  logic [16:0]               scaled;
  logic signed [17:0]        rounded;
  logic signed [9:0]         r3;

  assign ready3   = !out_valid || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1 && !status.busy;

  always_comb begin
    if (in_type == REQ_IMAGE) begin
      scaled = {1'b0, in_alpha} * {8'd0, status.factor} + IMG_ROUND;
    end else begin
      scaled = {1'b0, BOX_ALPHA} * {8'd0, status.factor} + BOX_ROUND;
    end
  end

  assign rounded = d2 + (d2 >>> 8) + BLEND_ROUND;
  assign r3      = rounded[17:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= in_valid && in_ready;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      a1    <= scaled[15:8];
      dest1 <= in_dest;
      skip1 <= (in_type == REQ_IMAGE) && (in_alpha == '0);
      if (in_type == REQ_IMAGE) begin
        diff1 <= $signed({1'b0, in_src}) - $signed({1'b0, in_dest});
      end else begin
        diff1 <= -$signed({1'b0, in_dest});
      end
    end
    if (ready2) begin
      d2    <= $signed({{9{diff1[SampleW]}}, diff1}) * $signed({10'd0, a1});
      dest2 <= dest1;
      skip2 <= skip1;
    end
    if (ready3) begin
      if (skip2) begin
        out_sample  <= dest2;
        out_changed <= 1'b0;
      end else begin
        out_sample  <= dest2 + r3[7:0];
        out_changed <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: verif/overlay_alpha_blend_fade_test.sv
// Self-checking testbench for the overlay alpha blend and fade compositor.
`timescale 1ns / 100ps
module overlay_alpha_blend_fade_test;
  import oabf_pkg::*;

  typedef struct {
    logic       req_type;
    logic [7:0] dest_sample;
    logic [7:0] src_sample;
    logic [7:0] src_alpha;
  } overlay_req_t;

  typedef struct {
    logic [7:0] out_sample;
    logic       changed;
  } blend_result_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic            cfg_index = REG_FADE_COUNT;
  logic [RegW-1:0] cfg_data = '0;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [23:0]     s_tdata = '0;  // dest_sample, src_sample, src_alpha
  logic            s_tuser = REQ_IMAGE;  // req_type
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [7:0]      m_tdata;  // out_sample
  logic            m_tuser;  // changed

  overlay_alpha_blend_fade DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  overlay_req_t          pending_reqs[$];
  blend_result_t         expected_blends[$];
  logic signed [RegW-1:0] fade_count_r = -11'sd1;
  logic signed [RegW-1:0] fade_max_r = -11'sd1;
  logic [FactorW-1:0]    fade_factor_r = FACTOR_NONE;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int reqs_queued = 0;
  int reqs_accepted = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int image_reqs = 0;
  int box_reqs = 0;
  int skipped_reqs = 0;
  int settings_used = 1;
  logic req_taken = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [FactorW-1:0] fade_factor_of(logic signed [RegW-1:0] cnt,
                                                        logic signed [RegW-1:0] mx);
    int c = cnt;
    int m = mx;
    if (m <= 0 || c < 0) return FACTOR_NONE;
    if (c >= m) return FACTOR_FULL;
    return FactorW'((512 * c + m) / (2 * m));
  endfunction

  function automatic logic [7:0] blend_toward(logic [7:0] dest, logic [7:0] src, int a);
    int d;
    int r;
    d = (int'(src) - int'(dest)) * a;
    r = (d + (d >>> 8) + 128) >>> 8;
    return 8'(int'(dest) + r);
  endfunction

  function automatic blend_result_t predict_blend(overlay_req_t r, logic [FactorW-1:0] factor);
    blend_result_t res;
    int a;
    res.changed = 1'b1;
    if (r.req_type == REQ_IMAGE) begin
      if (r.src_alpha == 8'd0) begin
        res.out_sample = r.dest_sample;
        res.changed = 1'b0;
        return res;
      end
      a = (int'(r.src_alpha) * int'(factor) + int'(IMG_ROUND)) >> 8;
      res.out_sample = blend_toward(r.dest_sample, r.src_sample, a);
    end else begin
      a = ((int'(BOX_ALPHA) * int'(factor) + int'(BOX_ROUND)) >> 8) & 8'hFF;
      res.out_sample = blend_toward(r.dest_sample, 8'd0, a);
    end
    return res;
  endfunction

  task automatic add_req(logic kind, logic [7:0] dest, logic [7:0] src, logic [7:0] alpha);
    overlay_req_t r;
    r.req_type = kind;
    r.dest_sample = dest;
    r.src_sample = src;
    r.src_alpha = alpha;
    pending_reqs = {pending_reqs, r};
    reqs_queued++;
  endtask

  function automatic logic [7:0] pick_sample();
    int sel = $urandom_range(0, 9);
    if (sel == 0) return 8'd0;
    if (sel == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  task automatic write_fade_reg(logic idx, logic signed [RegW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FADE_COUNT) fade_count_r = val;
    else fade_max_r = val;
    fade_factor_r = fade_factor_of(fade_count_r, fade_max_r);
    // The factor divider keeps the block busy for a while after each write.
    repeat (14) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (reqs_accepted != reqs_queued || expected_blends.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Request driver: new requests and receiver stalls change on the falling edge.
  always @(negedge clk) begin
    overlay_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= nxt.req_type;
        s_tdata <= {nxt.src_alpha, nxt.src_sample, nxt.dest_sample};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: predicts accepted requests and checks results on the rising edge.
  always @(posedge clk) begin
    overlay_req_t r;
    blend_result_t want;
    req_taken = !rst && s_tvalid && s_tready;
    if (req_taken) begin
      r.req_type = s_tuser;
      r.dest_sample = s_tdata[7:0];
      r.src_sample = s_tdata[15:8];
      r.src_alpha = s_tdata[23:16];
      expected_blends = {expected_blends, predict_blend(r, fade_factor_r)};
      reqs_accepted++;
      if (r.req_type == REQ_BOX) box_reqs++;
      else if (r.src_alpha == 8'd0) skipped_reqs++;
      else image_reqs++;
    end
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_blends.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result %0d arrived with nothing expected: out_sample=%0d changed=%0b",
                   results_seen, m_tdata, m_tuser);
      end else begin
        want = expected_blends.pop_front();
        if (m_tdata !== want.out_sample || m_tuser !== want.changed) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d: out_sample exp %0d got %0d, changed exp %0b got %0b",
                     results_seen, want.out_sample, m_tdata, want.changed, m_tuser);
        end
      end
    end
  end

  initial begin
    int fixed_count[9];
    int fixed_max[9];
    logic signed [RegW-1:0] cnt;
    logic signed [RegW-1:0] mx;
    int kind_sel;
    int alpha_sel;
    logic [7:0] alpha;
    fixed_count = '{1023, 0, -1, 1023, 0, 1, 511, 1022, 5};
    fixed_max = '{1023, 1, 1023, -1, 0, 1023, 1023, 1023, 3};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 77;

    // Directed requests at the reset fade setting.
    add_req(REQ_IMAGE, 8'd0, 8'd255, 8'd255);
    add_req(REQ_IMAGE, 8'd255, 8'd0, 8'd255);
    add_req(REQ_IMAGE, 8'd100, 8'd200, 8'd0);
    add_req(REQ_IMAGE, 8'd255, 8'd255, 8'd0);
    add_req(REQ_IMAGE, 8'd0, 8'd0, 8'd1);
    add_req(REQ_IMAGE, 8'd0, 8'd255, 8'd1);
    add_req(REQ_IMAGE, 8'd255, 8'd0, 8'd1);
    add_req(REQ_IMAGE, 8'd128, 8'd127, 8'd128);
    add_req(REQ_IMAGE, 8'hAA, 8'h55, 8'hAA);
    add_req(REQ_IMAGE, 8'h55, 8'hAA, 8'h55);
    add_req(REQ_IMAGE, 8'd200, 8'd200, 8'd255);
    add_req(REQ_IMAGE, 8'd1, 8'd254, 8'd254);
    add_req(REQ_BOX, 8'd255, 8'd0, 8'd0);
    add_req(REQ_BOX, 8'd0, 8'd255, 8'd255);
    add_req(REQ_BOX, 8'd1, 8'hAA, 8'd0);
    add_req(REQ_BOX, 8'h80, 8'h55, 8'h55);
    wait_drained();

    for (int phase = 0; phase < 16; phase++) begin
      if (phase < 9) begin
        cnt = RegW'(fixed_count[phase]);
        mx = RegW'(fixed_max[phase]);
        write_fade_reg(REG_FADE_COUNT, cnt);
        write_fade_reg(REG_FADE_MAX, mx);
      end else begin
        cnt = RegW'(int'($urandom_range(0, 1024)) - 1);
        mx = RegW'(int'($urandom_range(0, 1024)) - 1);
        if ($urandom_range(0, 3) != 0) write_fade_reg(REG_FADE_COUNT, cnt);
        if ($urandom_range(0, 3) != 0) write_fade_reg(REG_FADE_MAX, mx);
      end
      settings_used++;
      if (phase == 6) begin
        send_idle_pct = 77;
        recv_idle_pct = 11;
      end else if (phase == 11) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < 100; n++) begin
        kind_sel = $urandom_range(0, 3);
        alpha_sel = $urandom_range(0, 9);
        if (alpha_sel == 0) alpha = 8'd0;
        else if (alpha_sel == 1) alpha = 8'd255;
        else alpha = 8'($urandom);
        add_req(kind_sel == 0 ? REQ_BOX : REQ_IMAGE, pick_sample(), pick_sample(), alpha);
      end
      // The sender holds off here until every pending result has come back.
      wait_drained();
    end

    $display("Checked %0d results: %0d image blends, %0d zero-alpha skips, %0d box darkens,",
             results_seen, image_reqs, skipped_reqs, box_reqs);
    $display("across %0d fade settings; %0d mismatches.", settings_used, mismatch_count);
    if (mismatch_count == 0) begin
      $display("overlay_alpha_blend_fade_test: done, clean");
    end else begin
      $display("overlay_alpha_blend_fade_test: done, errors");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d results still expected.", expected_blends.size());
    $display("overlay_alpha_blend_fade_test: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
rtl/oabf_pkg.sv
rtl/oabf_fade.sv
rtl/oabf_blend.sv
rtl/overlay_alpha_blend_fade.sv
verif/overlay_alpha_blend_fade_test.sv
